// ===== hdl/qte_pkg.sv =====
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, types and constants of the quaternion to Euler angle core.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int ARG_W  = 35;   // arctangent arguments from the front end
    localparam int CW     = 37;   // CORDIC x and y datapath
    localparam int ZW     = 25;   // internal angle, 2^23 is pi
    localparam int SQ_W   = 62;   // square root radicand
    localparam int NU_W   = 31;   // scaled norm and pitch sine term
    localparam int OUT_W  = 16;

    localparam logic signed [ZW-1:0] ANG_HALF_PI = 25'sd4194304;

    // Everything that rides alongside the pitch square root.
    typedef struct packed {
        logic                    zero;
        logic                    lock;
        logic                    neg;
        logic [NU_W-1:0]         sa;
        logic signed [ARG_W-1:0] yaw_y;
        logic signed [ARG_W-1:0] yaw_x;
        logic signed [ARG_W-1:0] roll_y;
        logic signed [ARG_W-1:0] roll_x;
    } t_side;

    function automatic logic signed [ZW-1:0] atan_entry(input int unsigned idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:  v = 25'sd2097152;
            1:  v = 25'sd1238021;
            2:  v = 25'sd654136;
            3:  v = 25'sd332050;
            4:  v = 25'sd166669;
            5:  v = 25'sd83416;
            6:  v = 25'sd41718;
            7:  v = 25'sd20860;
            8:  v = 25'sd10430;
            9:  v = 25'sd5215;
            10: v = 25'sd2608;
            11: v = 25'sd1304;
            12: v = 25'sd652;
            13: v = 25'sd326;
            14: v = 25'sd163;
            15: v = 25'sd81;
            16: v = 25'sd41;
            17: v = 25'sd20;
            18: v = 25'sd10;
            19: v = 25'sd5;
            20: v = 25'sd3;
            21: v = 25'sd1;
            22: v = 25'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Round the internal angle to the 16-bit output unit, wrapping at pi.
    function automatic logic [OUT_W-1:0] to_out(input logic signed [ZW-1:0] a);
        logic signed [ZW:0] t;
        t = (ZW+1)'(a) + (ZW+1)'(128);
        return t[OUT_W+7:8];
    endfunction

endpackage

// ===== hdl/quaternion_to_euler_angles_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_core
// Converts a Q1.14 quaternion to Z-Y-X yaw, pitch and roll binary angles.
// ----------------------------------------------------------------------------
// Usage: drive i_comp_w/x/y/z and pulse start; a request is taken at every
// clock edge with start high, since busy is always low. The block is fully
// pipelined and takes one request per cycle.
// Each result appears on o_yaw_angle, o_pitch_angle, o_roll_angle and
// o_zero_norm for exactly one cycle, marked by o_valid, in request order.
// A request passes the stages of products, sums and squares, the
// bit-per-stage pitch square root, the three parallel CORDIC units and one
// output register. The receiver cannot stall the block.
// Reset clears the valid bits of all stages, so no stale result is shown.
// Angles use 32768 for pi; an all-zero input sets o_zero_norm with zero
// angles.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_comp_w,
    input  logic signed [15:0] i_comp_x,
    input  logic signed [15:0] i_comp_y,
    input  logic signed [15:0] i_comp_z,
    output logic               o_valid,
    output logic signed [15:0] o_yaw_angle,
    output logic signed [15:0] o_pitch_angle,
    output logic signed [15:0] o_roll_angle,
    output logic               o_zero_norm
);

    logic                             f_valid;
    logic [qte_pkg::SQ_W-1:0]         f_diff;
    qte_pkg::t_side                   f_side;
    logic                             s_valid;
    logic [qte_pkg::NU_W-1:0]         s_root;
    qte_pkg::t_side                   s_side;

    logic signed [qte_pkg::CW-1:0]    c_yaw_y, c_yaw_x, c_roll_y, c_roll_x;
    logic signed [qte_pkg::CW-1:0]    c_pit_y, c_pit_x;
    logic signed [qte_pkg::ZW-1:0]    a_yaw, a_roll, a_pit;

    logic                             r_dv [0:CORDIC_STEPS];
    logic                             r_dz [0:CORDIC_STEPS];
    logic                             r_dl [0:CORDIC_STEPS];
    logic                             r_dn [0:CORDIC_STEPS];

    logic                             r_valid, r_zero;
    logic [15:0]                      r_yaw, r_pitch, r_roll;
    logic signed [qte_pkg::ZW-1:0]    n_pit;

    assign busy = 1'b0;

    qte_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_w     (i_comp_w),
        .i_x     (i_comp_x),
        .i_y     (i_comp_y),
        .i_z     (i_comp_z),
        .o_valid (f_valid),
        .o_diff  (f_diff),
        .o_side  (f_side)
    );

    qte_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_v     (f_diff),
        .i_side  (f_side),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    assign c_yaw_y  = qte_pkg::CW'(s_side.yaw_y);
    assign c_yaw_x  = qte_pkg::CW'(s_side.yaw_x);
    assign c_roll_y = qte_pkg::CW'(s_side.roll_y);
    assign c_roll_x = qte_pkg::CW'(s_side.roll_x);
    assign c_pit_y  = qte_pkg::CW'(s_side.sa);
    assign c_pit_x  = qte_pkg::CW'(s_root);

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_yaw (
        .i_clk (i_clk),
        .i_y   (c_yaw_y),
        .i_x   (c_yaw_x),
        .o_ang (a_yaw)
    );

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_roll (
        .i_clk (i_clk),
        .i_y   (c_roll_y),
        .i_x   (c_roll_x),
        .o_ang (a_roll)
    );

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_pitch (
        .i_clk (i_clk),
        .i_y   (c_pit_y),
        .i_x   (c_pit_x),
        .o_ang (a_pit)
    );

    // Flags follow the CORDIC stages so they meet their angles at the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else begin
            r_dv[0] <= s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dz[0] <= s_side.zero;
        r_dl[0] <= s_side.lock;
        r_dn[0] <= s_side.neg;
    end

    genvar k;
    generate
        for (k = 0; k < CORDIC_STEPS; k++) begin : g_dly
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv[k+1] <= 1'b0;
                end else begin
                    r_dv[k+1] <= r_dv[k];
                end
            end

            always_ff @(posedge i_clk) begin
                r_dz[k+1] <= r_dz[k];
                r_dl[k+1] <= r_dl[k];
                r_dn[k+1] <= r_dn[k];
            end
        end
    endgenerate

    always_comb begin
        if (r_dl[CORDIC_STEPS]) begin
            n_pit = qte_pkg::ANG_HALF_PI;
        end else if (a_pit > qte_pkg::ANG_HALF_PI) begin
            n_pit = qte_pkg::ANG_HALF_PI;
        end else if (a_pit < 0) begin
            n_pit = '0;
        end else begin
            n_pit = a_pit;
        end
        if (r_dn[CORDIC_STEPS]) begin
            n_pit = -n_pit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_dv[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero <= r_dz[CORDIC_STEPS];
        if (r_dz[CORDIC_STEPS]) begin
            r_yaw   <= '0;
            r_pitch <= '0;
            r_roll  <= '0;
        end else begin
            r_yaw   <= qte_pkg::to_out(a_yaw);
            r_pitch <= qte_pkg::to_out(n_pit);
            r_roll  <= qte_pkg::to_out(a_roll);
        end
    end

    assign o_valid       = r_valid;
    assign o_zero_norm   = r_zero;
    assign o_yaw_angle   = r_yaw;
    assign o_pitch_angle = r_pitch;
    assign o_roll_angle  = r_roll;

endmodule

// ===== hdl/qte_front.sv =====
// ----------------------------------------------------------------------------
// qte_front
// Products, sums, gimbal lock test and radicand for the pitch square root.
// ----------------------------------------------------------------------------
module qte_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic signed [15:0]                i_w,
    input  logic signed [15:0]                i_x,
    input  logic signed [15:0]                i_y,
    input  logic signed [15:0]                i_z,
    output logic                              o_valid,
    output logic [qte_pkg::SQ_W-1:0]          o_diff,
    output qte_pkg::t_side                    o_side
);

    // Stage 1: products.
    logic               r1_valid, r1_zero;
    logic signed [31:0] r1_ww, r1_xx, r1_yy, r1_zz;
    logic signed [31:0] r1_wz, r1_xy, r1_wx, r1_yz, r1_wy, r1_zx;
    // Stage 2: sums.
    logic                                     r2_valid, r2_zero;
    logic [32:0]                              r2_n2;
    logic signed [qte_pkg::ARG_W-1:0]         r2_yaw_y, r2_yaw_x, r2_roll_y, r2_roll_x, r2_s;
    logic signed [qte_pkg::ARG_W-1:0]         n_n2;
    // Stage 3: magnitude, lock test and scaling.
    logic                                     r3_valid;
    logic [qte_pkg::NU_W-1:0]                 r3_nu;
    qte_pkg::t_side                           r3_side;
    logic [32:0]                              n_sa;
    logic                                     n_big;
    // Stage 4: squares.
    logic                                     r4_valid;
    logic [qte_pkg::SQ_W-1:0]                 r4_nn, r4_ss;
    qte_pkg::t_side                           r4_side;
    // Stage 5: radicand.
    logic                                     r5_valid;
    logic [qte_pkg::SQ_W-1:0]                 r5_diff;
    qte_pkg::t_side                           r5_side;

    always_comb begin
        n_n2  = 35'(r1_ww) + 35'(r1_xx) + 35'(r1_yy) + 35'(r1_zz);
        n_sa  = r2_s[qte_pkg::ARG_W-1] ? 33'(-r2_s) : 33'(r2_s);
        n_big = (r2_n2[32:31] != 2'b00);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_zero <= (i_w == 16'sd0) && (i_x == 16'sd0) && (i_y == 16'sd0) && (i_z == 16'sd0);
        r1_ww   <= 32'(i_w) * 32'(i_w);
        r1_xx   <= 32'(i_x) * 32'(i_x);
        r1_yy   <= 32'(i_y) * 32'(i_y);
        r1_zz   <= 32'(i_z) * 32'(i_z);
        r1_wz   <= 32'(i_w) * 32'(i_z);
        r1_xy   <= 32'(i_x) * 32'(i_y);
        r1_wx   <= 32'(i_w) * 32'(i_x);
        r1_yz   <= 32'(i_y) * 32'(i_z);
        r1_wy   <= 32'(i_w) * 32'(i_y);
        r1_zx   <= 32'(i_z) * 32'(i_x);

        r2_zero   <= r1_zero;
        r2_n2     <= n_n2[32:0];
        r2_yaw_y  <= (35'(r1_wz) + 35'(r1_xy)) <<< 1;
        r2_yaw_x  <= 35'(r1_ww) + 35'(r1_xx) - 35'(r1_yy) - 35'(r1_zz);
        r2_roll_y <= (35'(r1_wx) + 35'(r1_yz)) <<< 1;
        r2_roll_x <= 35'(r1_ww) + 35'(r1_zz) - 35'(r1_xx) - 35'(r1_yy);
        r2_s      <= (35'(r1_wy) - 35'(r1_zx)) <<< 1;

        // Large norms are scaled by four so the squares stay within 62 bits.
        r3_nu          <= n_big ? r2_n2[32:2] : r2_n2[30:0];
        r3_side.zero   <= r2_zero;
        r3_side.lock   <= (n_sa >= r2_n2);
        r3_side.neg    <= r2_s[qte_pkg::ARG_W-1];
        r3_side.sa     <= n_big ? n_sa[32:2] : n_sa[30:0];
        r3_side.yaw_y  <= r2_yaw_y;
        r3_side.yaw_x  <= r2_yaw_x;
        r3_side.roll_y <= r2_roll_y;
        r3_side.roll_x <= r2_roll_x;

        r4_nn   <= 62'(r3_nu) * 62'(r3_nu);
        r4_ss   <= 62'(r3_side.sa) * 62'(r3_side.sa);
        r4_side <= r3_side;

        r5_diff <= r4_nn - r4_ss;
        r5_side <= r4_side;
    end

    assign o_valid = r5_valid;
    assign o_diff  = r5_diff;
    assign o_side  = r5_side;

endmodule

// ===== hdl/qte_isqrt.sv =====
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qte_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [qte_pkg::SQ_W-1:0]      i_v,
    input  qte_pkg::t_side                i_side,
    output logic                          o_valid,
    output logic [qte_pkg::NU_W-1:0]      o_root,
    output qte_pkg::t_side                o_side
);

    localparam int NST = qte_pkg::NU_W;

    logic                         r_valid [0:NST-1];
    logic [qte_pkg::SQ_W-1:0]     r_v     [0:NST-1];
    logic [qte_pkg::SQ_W:0]       r_res   [0:NST-1];
    qte_pkg::t_side               r_side  [0:NST-1];

    genvar j;
    generate
        for (j = 0; j < NST; j++) begin : g_st
            localparam int K = NST - 1 - j;
            logic                     p_valid;
            logic [qte_pkg::SQ_W-1:0] p_v;
            logic [qte_pkg::SQ_W:0]   p_res, trial, bitv;
            qte_pkg::t_side           p_side;
            logic                     take;

            if (j == 0) begin : g_first
                assign p_valid = i_valid;
                assign p_v     = i_v;
                assign p_res   = '0;
                assign p_side  = i_side;
            end else begin : g_next
                assign p_valid = r_valid[j-1];
                assign p_v     = r_v[j-1];
                assign p_res   = r_res[j-1];
                assign p_side  = r_side[j-1];
            end

            always_comb begin
                bitv  = (qte_pkg::SQ_W+1)'(1) << (2 * K);
                trial = p_res + bitv;
                take  = ({1'b0, p_v} >= trial);
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[j] <= 1'b0;
                end else begin
                    r_valid[j] <= p_valid;
                end
            end

            always_ff @(posedge i_clk) begin
                r_v[j]    <= take ? (p_v - trial[qte_pkg::SQ_W-1:0]) : p_v;
                r_res[j]  <= take ? ((p_res >> 1) + bitv) : (p_res >> 1);
                r_side[j] <= p_side;
            end
        end
    endgenerate

    assign o_valid = r_valid[NST-1];
    assign o_root  = r_res[NST-1][qte_pkg::NU_W-1:0];
    assign o_side  = r_side[NST-1];

endmodule

// ===== hdl/qte_cordic.sv =====
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined CORDIC vectoring arctangent, one micro-rotation per stage.
// ----------------------------------------------------------------------------
module qte_cordic #(
    parameter int STEPS = 16
) (
    input  logic                              i_clk,
    input  logic signed [qte_pkg::CW-1:0]     i_y,
    input  logic signed [qte_pkg::CW-1:0]     i_x,
    output logic signed [qte_pkg::ZW-1:0]     o_ang
);

    logic signed [qte_pkg::CW-1:0] r_x    [0:STEPS];
    logic signed [qte_pkg::CW-1:0] r_y    [0:STEPS];
    logic signed [qte_pkg::ZW-1:0] r_z    [0:STEPS];
    logic                          r_zero [0:STEPS];

    logic signed [qte_pkg::CW-1:0] n_x, n_y;
    logic signed [qte_pkg::ZW-1:0] n_z;

    // Left half-plane inputs are turned by a quarter turn first.
    always_comb begin
        n_x = i_x;
        n_y = i_y;
        n_z = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_x = i_y;
                n_y = -i_x;
                n_z = qte_pkg::ANG_HALF_PI;
            end else begin
                n_x = -i_y;
                n_y = i_x;
                n_z = -qte_pkg::ANG_HALF_PI;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= n_x;
        r_y[0]    <= n_y;
        r_z[0]    <= n_z;
        r_zero[0] <= (i_x == 0) && (i_y == 0);
    end

    genvar i;
    generate
        for (i = 0; i < STEPS; i++) begin : g_rot
            always_ff @(posedge i_clk) begin
                if (r_y[i] < 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - qte_pkg::atan_entry(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + qte_pkg::atan_entry(i);
                end
                r_zero[i+1] <= r_zero[i];
            end
        end
    endgenerate

    assign o_ang = r_zero[STEPS] ? '0 : r_z[STEPS];

endmodule
